// ----- src/aprp_pkg.sv -----
package aprp_pkg;

	localparam int PAGES_DFLT        = 256;
	localparam int FRAMES_DFLT       = 16;
	localparam int PG_BYTES_DFLT     = 256;
	localparam int COUNTER_BITS_DFLT = 8;

	localparam int VA_W       = 16;
	localparam int PA_W       = 12;
	localparam int EVP_W      = 8;
	localparam int FAULT_W    = 32;
	localparam int PIU_W      = 9;
	localparam int FIU_W      = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [PIU_W-1:0] PAGES_IN_USE_RST  = 9'd256;
	localparam logic [FIU_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 4'd1;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TICK,
		CMD_REF,
		CMD_PLACE,
		CMD_EVICT
	} cell_op_t;

	typedef struct packed {
		op_t              op;
		logic [VA_W-1:0]  virt_addr;
	} access_t;

	typedef struct packed {
		logic [PA_W-1:0]    xlat_addr;
		logic               fault;
		logic               bad_address;
		logic               evicted;
		logic [EVP_W-1:0]   evicted_page;
		logic [FAULT_W-1:0] faults_so_far;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

// ----- src/aprp_stream_if.sv -----
interface aprp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/aprp_cell.sv -----
module aprp_cell #(
	parameter int  PAGES        = aprp_pkg::PAGES_DFLT,
	parameter int  FRAMES       = aprp_pkg::FRAMES_DFLT,
	parameter int  COUNTER_BITS = aprp_pkg::COUNTER_BITS_DFLT,
	parameter int  IDX          = 0,
	parameter type cmd_t        = logic,
	parameter type rec_t        = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic tok_in,
	input  rec_t rec_in,
	output logic tok_out,
	output rec_t rec_out,
	output logic valid,
	output logic hit
);
	import aprp_pkg::*;

	localparam int FW = $clog2(FRAMES);
	localparam int OW = $clog2(PAGES);
	localparam int CW = COUNTER_BITS;
	localparam int NW = $clog2(FRAMES + 1);
	localparam logic [FW-1:0] ME   = FW'(IDX);
	localparam logic [NW-1:0] ME_N = NW'(IDX);

	logic          valid_q;
	logic [OW-1:0] owner_q;
	logic [CW-1:0] cnt_q;
	logic          ref_q;
	logic [FW-1:0] rank_q;
	logic          tok_q;
	rec_t          rec_q;
	rec_t          rec_nxt;
	logic          sel;
	logic          fill;
	logic          shift_down;

	assign sel        = (cmd.frame == ME);
	assign fill       = sel && (cmd.kind == CMD_PLACE || cmd.kind == CMD_EVICT);
	assign shift_down = !sel && cmd.kind == CMD_EVICT && valid_q && rank_q > cmd.old_rank;

	always_comb begin
		rec_nxt = rec_in;
		if (ME_N < cmd.lim_frames) begin
			if (!valid_q) begin
				rec_nxt.have_free = 1'b1;
				rec_nxt.free_idx  = ME;
			end else if (!rec_in.have_best || cnt_q < rec_in.best_cnt ||
			             (cnt_q == rec_in.best_cnt && rank_q < rec_in.best_rank)) begin
				rec_nxt.have_best  = 1'b1;
				rec_nxt.best_idx   = ME;
				rec_nxt.best_cnt   = cnt_q;
				rec_nxt.best_rank  = rank_q;
				rec_nxt.best_owner = owner_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
			ref_q   <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			unique case (cmd.kind)
				CMD_TICK: begin
					if (valid_q) begin
						cnt_q <= {ref_q, cnt_q[CW-1:1]};
						ref_q <= 1'b0;
					end
				end
				CMD_REF: begin
					if (sel) ref_q <= 1'b1;
				end
				CMD_PLACE, CMD_EVICT: begin
					if (sel) begin
						valid_q <= 1'b1;
						cnt_q   <= '0;
						ref_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_nxt;
		if (fill) begin
			owner_q <= cmd.page;
			rank_q  <= cmd.rank;
		end else if (shift_down) begin
			rank_q <= rank_q - 1'b1;
		end
	end

	assign tok_out = tok_q;
	assign rec_out = rec_q;
	assign valid   = valid_q;
	assign hit     = valid_q && (owner_q == cmd.page);

endmodule

// ----- src/aging_page_replacer.sv -----
// Aging page replacer: translates virtual addresses to physical frames.
// Channels: access (sink) takes an op and a virtual address, result (source)
// returns one item per access or tick, cfg (sink) writes pages_in_use
// (index 0) and frames_in_use (index 1); cfg is always ready.
// Each frame is a cell in a chain holding its owner page, aging counter,
// reference bit and residency rank. A lookup compares all cells at once.
// Flow: a tick, a bad address or a resident page passes from the access transfer
// through S_LOOK and S_DONE into the output register; a fault goes to S_SWEEP,
// where a search token passes down the chain, one cell per cycle, then S_DONE.
// The next access is taken the cycle after the load, so one access is handled
// at a time; the output register holds a result while the receiver stalls and
// the next access still proceeds up to its own result.
// Reset empties every frame, clears counters, reference bits and the fault
// total, and sets pages_in_use and frames_in_use to their full values.
module aging_page_replacer #(
	parameter int PAGES        = aprp_pkg::PAGES_DFLT,
	parameter int FRAMES       = aprp_pkg::FRAMES_DFLT,
	parameter int PG_BYTES     = aprp_pkg::PG_BYTES_DFLT,
	parameter int COUNTER_BITS = aprp_pkg::COUNTER_BITS_DFLT
) (
	input logic           clk,
	input logic           arst_n,
	aprp_stream_if.sink   cfg,
	aprp_stream_if.sink   access,
	aprp_stream_if.source result
);
	import aprp_pkg::*;

	localparam int FW    = $clog2(FRAMES);
	localparam int OW    = $clog2(PAGES);
	localparam int CW    = COUNTER_BITS;
	localparam int NW    = $clog2(FRAMES + 1);
	localparam int OFF_W = $clog2(PG_BYTES);

	typedef struct packed {
		cell_op_t      kind;
		logic [FW-1:0] frame;
		logic [OW-1:0] page;
		logic [FW-1:0] rank;
		logic [FW-1:0] old_rank;
		logic [NW-1:0] lim_frames;
	} cmd_t;

	typedef struct packed {
		logic          have_free;
		logic [FW-1:0] free_idx;
		logic          have_best;
		logic [FW-1:0] best_idx;
		logic [CW-1:0] best_cnt;
		logic [FW-1:0] best_rank;
		logic [OW-1:0] best_owner;
	} rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SWEEP,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [PIU_W-1:0]     pages_q;
	logic [FIU_W-1:0]     frames_q;
	op_t                  op_q;
	logic [OW-1:0]        page_q;
	logic [OFF_W-1:0]     off_q;
	logic                 bad_q;
	logic                 fault_q;
	logic                 ev_q;
	logic [EVP_W-1:0]     evp_q;
	logic [FW-1:0]        frame_q;
	logic [NW-1:0]        frames_used_q;
	logic [FAULT_W-1:0]   fault_total_q;
	logic                 res_valid_q;
	result_t              res_q;

	logic [NW-1:0]        eff_n;
	logic [VA_W-1:0]      pg_lim;
	logic [VA_W-1:0]      page_full;
	logic                 acc_bad;
	cmd_t                 cmd;
	logic [FRAMES:0]      tok;
	rec_t                 rec [FRAMES+1];
	logic [FRAMES-1:0]    cell_valid;
	logic [FRAMES-1:0]    hit_vec;
	logic                 any_hit;
	logic [FW-1:0]        hit_idx;
	logic                 tail;
	rec_t                 tail_rec;

	always_comb begin
		if (frames_q == '0) begin
			eff_n = NW'(1);
		end else if (32'(frames_q) > 32'(FRAMES)) begin
			eff_n = NW'(FRAMES);
		end else begin
			eff_n = NW'(frames_q);
		end
		if (32'(pages_q) > 32'(PAGES)) begin
			pg_lim = VA_W'(PAGES);
		end else begin
			pg_lim = VA_W'(pages_q);
		end
	end

	assign page_full = access.data.virt_addr >> OFF_W;
	assign acc_bad   = (access.data.op == OP_ACCESS) && (page_full >= pg_lim);

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (hit_vec[i]) hit_idx = hit_idx | FW'(i);
		end
	end
	assign any_hit = |hit_vec;

	assign tail     = tok[FRAMES];
	assign tail_rec = rec[FRAMES];

	always_comb begin
		cmd            = '0;
		cmd.kind       = CMD_NONE;
		cmd.page       = page_q;
		cmd.lim_frames = eff_n;
		if (state_q == S_LOOK) begin
			if (op_q == OP_TICK) begin
				cmd.kind = CMD_TICK;
			end else if (!bad_q && any_hit) begin
				cmd.kind  = CMD_REF;
				cmd.frame = hit_idx;
			end
		end else if (state_q == S_SWEEP && tail) begin
			if (tail_rec.have_free) begin
				cmd.kind  = CMD_PLACE;
				cmd.frame = tail_rec.free_idx;
				cmd.rank  = FW'(frames_used_q);
			end else begin
				cmd.kind     = CMD_EVICT;
				cmd.frame    = tail_rec.best_idx;
				cmd.rank     = FW'(frames_used_q - 1'b1);
				cmd.old_rank = tail_rec.best_rank;
			end
		end
	end

	assign tok[0] = (state_q == S_LOOK) && (op_q == OP_ACCESS) && !bad_q && !any_hit;
	assign rec[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		aprp_cell #(
			.PAGES        (PAGES),
			.FRAMES       (FRAMES),
			.COUNTER_BITS (COUNTER_BITS),
			.IDX          (i),
			.cmd_t        (cmd_t),
			.rec_t        (rec_t)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok[i]),
			.rec_in  (rec[i]),
			.tok_out (tok[i+1]),
			.rec_out (rec[i+1]),
			.valid   (cell_valid[i]),
			.hit     (hit_vec[i])
		);
	end

	assign cfg.ready    = 1'b1;
	assign access.ready = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q  <= PAGES_IN_USE_RST;
			frames_q <= FRAMES_IN_USE_RST;
		end else if (cfg.valid) begin
			if (cfg.data.index == CFG_PAGES_IN_USE) begin
				pages_q <= cfg.data.wdata[PIU_W-1:0];
			end else if (cfg.data.index == CFG_FRAMES_IN_USE) begin
				frames_q <= cfg.data.wdata[FIU_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_ACCESS;
			page_q        <= '0;
			off_q         <= '0;
			bad_q         <= 1'b0;
			fault_q       <= 1'b0;
			ev_q          <= 1'b0;
			evp_q         <= '0;
			frame_q       <= '0;
			frames_used_q <= '0;
			fault_total_q <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (result.ready && state_q != S_DONE) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (access.valid) begin
						op_q    <= access.data.op;
						page_q  <= OW'(page_full);
						off_q   <= access.data.virt_addr[OFF_W-1:0];
						bad_q   <= acc_bad;
						fault_q <= 1'b0;
						ev_q    <= 1'b0;
						evp_q   <= '0;
						frame_q <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (op_q == OP_TICK || bad_q) begin
						state_q <= S_DONE;
					end else if (any_hit) begin
						frame_q <= hit_idx;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (tail) begin
						fault_total_q <= fault_total_q + 1'b1;
						fault_q       <= 1'b1;
						if (tail_rec.have_free) begin
							frame_q       <= tail_rec.free_idx;
							frames_used_q <= frames_used_q + 1'b1;
						end else begin
							frame_q <= tail_rec.best_idx;
							ev_q    <= 1'b1;
							evp_q   <= EVP_W'(tail_rec.best_owner);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q             <= 1'b1;
						res_q.xlat_addr         <= (op_q == OP_ACCESS && !bad_q) ?
						                           PA_W'({frame_q, off_q}) : '0;
						res_q.fault             <= fault_q;
						res_q.bad_address       <= bad_q;
						res_q.evicted           <= ev_q;
						res_q.evicted_page      <= evp_q;
						res_q.faults_so_far     <= fault_total_q;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(frames_used_q) == $countones(cell_valid))
		else $error("resident frame count out of step with cell valid bits");

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("page resident in more than one frame");

	a_tail_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tail |-> state_q == S_SWEEP)
		else $error("search token left the chain outside a sweep");

	a_sweep_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && tail) |=> (state_q == S_DONE && fault_q))
		else $error("finished sweep did not record a fault");

endmodule
